// ===== rtl/ebu_pkg.sv =====
// Shared types and constants for the extended gcd / Bezout coefficient unit.
// No dependencies; every other file imports this package.
package ebu_pkg;

    // Operand width; coefficients are kept modulo 2^COEFF_BITS
    localparam int OPERAND_BITS = 32;
    localparam int COEFF_BITS   = 33;
    localparam int CNT_BITS     = $clog2(OPERAND_BITS);

    typedef logic [OPERAND_BITS-1:0]      operand_t;
    typedef logic signed [COEFF_BITS-1:0] coeff_t;
    typedef logic [CNT_BITS-1:0]          cnt_t;

    // Starting coefficient pairs {s, t}: previous row {1, 0}, current row {0, 1}
    localparam coeff_t COEFF_ZERO = coeff_t'(0);
    localparam coeff_t COEFF_ONE  = coeff_t'(1);

    // Control from the top level to the round engine
    typedef struct packed {
        logic start;    // load a fresh operand pair
        logic release_; // result taken, return to idle
    } ebu_ctrl_t;

    // Status from the round engine to the top level
    typedef struct packed {
        logic done;     // b has reached zero, coefficients are final
    } ebu_stat_t;

endpackage

// ===== rtl/ebu_in_if.sv =====
// Request channel carrying the operand pair.
// Depends on ebu_pkg for the operand type.
interface ebu_in_if;
    import ebu_pkg::*;

    logic     valid;
    logic     ready;
    operand_t first_operand;
    operand_t second_operand;

    modport source (output valid, output first_operand, output second_operand, input ready);
    modport sink   (input valid, input first_operand, input second_operand, output ready);
endinterface

// ===== rtl/ebu_out_if.sv =====
// Result channel carrying the two Bezout coefficients.
// Depends on ebu_pkg for the coefficient type.
interface ebu_out_if;
    import ebu_pkg::*;

    logic   valid;
    logic   ready;
    coeff_t coeff_first;
    coeff_t coeff_second;

    modport source (output valid, output coeff_first, output coeff_second, input ready);
    modport sink   (input valid, input coeff_first, input coeff_second, output ready);
endinterface

// ===== rtl/extended_gcd_bezout_unit.sv =====
// Top level of the extended gcd unit: request handshake, round engine, result register.
// Depends on ebu_pkg, ebu_in_if, ebu_out_if and ebu_round.
//
//  channel   dir  interface   payload
//  operands  in   ebu_in_if   first_operand, second_operand (32b unsigned)
//  coeffs    out  ebu_out_if  coeff_first, coeff_second (33b signed)
//
// A request runs one round for each Euclid division, and the bit-serial divider
// (one quotient bit a cycle) walks all OPERAND_BITS dividend bits in every round.
// Reset clears the sequencer and the result valid flag.
// A new request is taken once the previous result sits in the output register;
// a stalled result holds the engine in its done phase.
module extended_gcd_bezout_unit (
    input logic       clk,
    input logic       rst_n,
    ebu_in_if.sink    operands,
    ebu_out_if.source coeffs
);
    import ebu_pkg::*;

    ebu_ctrl_t ctrl;
    ebu_stat_t stat;
    coeff_t    s_final;
    coeff_t    t_final;

    logic   busy_reg, busy_next;
    logic   out_valid_reg, out_valid_next;
    coeff_t out_s_reg;
    coeff_t out_t_reg;
    logic   take_req;
    logic   move_out;

    assign operands.ready = ~busy_reg;
    assign take_req       = operands.valid & ~busy_reg;
    assign move_out       = stat.done & (~out_valid_reg | coeffs.ready);

    assign ctrl.start    = take_req;
    assign ctrl.release_ = move_out;

    ebu_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .a_in  (operands.first_operand),
        .b_in  (operands.second_operand),
        .stat  (stat),
        .s_out (s_final),
        .t_out (t_final)
    );

    // Track the busy engine and the result slot
    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (coeffs.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (move_out)
        begin
            out_valid_next = 1'b1;
            busy_next      = 1'b0;
        end
        if (take_req)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the final coefficients
    always_ff @(posedge clk)
    begin
        if (move_out)
        begin
            out_s_reg <= s_final;
            out_t_reg <= t_final;
        end
    end

    assign coeffs.valid        = out_valid_reg;
    assign coeffs.coeff_first  = out_s_reg;
    assign coeffs.coeff_second = out_t_reg;

endmodule

// ===== rtl/ebu_round.sv =====
// Round engine: bit-serial restoring divider that folds q*s and q*t in as the
// quotient bits appear, then updates the remainder and coefficient pairs.
// Depends on ebu_pkg.
module ebu_round (
    input  logic              clk,
    input  logic              rst_n,
    input  ebu_pkg::ebu_ctrl_t ctrl,
    input  ebu_pkg::operand_t a_in,
    input  ebu_pkg::operand_t b_in,
    output ebu_pkg::ebu_stat_t stat,
    output ebu_pkg::coeff_t   s_out,
    output ebu_pkg::coeff_t   t_out
);
    import ebu_pkg::*;

    localparam logic [2:0] P_IDLE   = 3'd0;
    localparam logic [2:0] P_CHECK  = 3'd1;
    localparam logic [2:0] P_DIV    = 3'd2;
    localparam logic [2:0] P_UPDATE = 3'd3;
    localparam logic [2:0] P_DONE   = 3'd4;

    localparam cnt_t CNT_LAST = cnt_t'(OPERAND_BITS - 1);

    logic [2:0] phase_reg, phase_next;
    cnt_t       cnt_reg, cnt_next;

    operand_t a_reg, a_next;
    operand_t b_reg, b_next;
    operand_t rem_reg, rem_next;
    operand_t dvd_reg, dvd_next;
    coeff_t   prev_s_reg, prev_s_next;
    coeff_t   prev_t_reg, prev_t_next;
    coeff_t   curr_s_reg, curr_s_next;
    coeff_t   curr_t_reg, curr_t_next;
    coeff_t   acc_s_reg, acc_s_next;
    coeff_t   acc_t_reg, acc_t_next;

    // Shared divide step: shift in one dividend bit, trial subtract b
    logic [OPERAND_BITS:0] rem_shift;
    logic [OPERAND_BITS:0] rem_diff;
    logic                  q_bit;

    assign rem_shift = {rem_reg, dvd_reg[OPERAND_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, b_reg};
    assign q_bit     = ~rem_diff[OPERAND_BITS];

    // Sequence the rounds
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        prev_s_next = prev_s_reg;
        prev_t_next = prev_t_reg;
        curr_s_next = curr_s_reg;
        curr_t_next = curr_t_reg;
        acc_s_next  = acc_s_reg;
        acc_t_next  = acc_t_reg;

        case (phase_reg)
            P_IDLE:
            begin
                if (ctrl.start)
                begin
                    a_next      = a_in;
                    b_next      = b_in;
                    prev_s_next = COEFF_ONE;
                    prev_t_next = COEFF_ZERO;
                    curr_s_next = COEFF_ZERO;
                    curr_t_next = COEFF_ONE;
                    phase_next  = P_CHECK;
                end
            end
            P_CHECK:
            begin
                // Stop once b is zero, otherwise prime the divider
                if (b_reg == '0)
                begin
                    phase_next = P_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    dvd_next   = a_reg;
                    acc_s_next = COEFF_ZERO;
                    acc_t_next = COEFF_ZERO;
                    cnt_next   = '0;
                    phase_next = P_DIV;
                end
            end
            P_DIV:
            begin
                // One quotient bit per cycle; accumulate q*s and q*t Horner style
                rem_next   = q_bit ? rem_diff[OPERAND_BITS-1:0]
                                   : rem_shift[OPERAND_BITS-1:0];
                dvd_next   = {dvd_reg[OPERAND_BITS-2:0], 1'b0};
                acc_s_next = {acc_s_reg[COEFF_BITS-2:0], 1'b0}
                             + (q_bit ? curr_s_reg : COEFF_ZERO);
                acc_t_next = {acc_t_reg[COEFF_BITS-2:0], 1'b0}
                             + (q_bit ? curr_t_reg : COEFF_ZERO);
                cnt_next   = cnt_reg + cnt_t'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    phase_next = P_UPDATE;
                end
            end
            P_UPDATE:
            begin
                // Shift the pair down and advance the coefficient rows
                a_next      = b_reg;
                b_next      = rem_reg;
                prev_s_next = curr_s_reg;
                prev_t_next = curr_t_reg;
                curr_s_next = prev_s_reg - acc_s_reg;
                curr_t_next = prev_t_reg - acc_t_reg;
                phase_next  = P_CHECK;
            end
            P_DONE:
            begin
                if (ctrl.release_)
                begin
                    phase_next = P_IDLE;
                end
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        prev_s_reg <= prev_s_next;
        prev_t_reg <= prev_t_next;
        curr_s_reg <= curr_s_next;
        curr_t_reg <= curr_t_next;
        acc_s_reg  <= acc_s_next;
        acc_t_reg  <= acc_t_next;
    end

    assign stat.done = (phase_reg == P_DONE);
    assign s_out     = prev_s_reg;
    assign t_out     = prev_t_reg;

endmodule
